FILE: src/spre_pkg.sv
// spre_pkg: widths, reset values, register indexes, state codes and the
// request structs shared by the send pacer top level and its serial units.
// No dependencies.
`timescale 1ns / 1ps

package spre_pkg;

	localparam int TIME_W    = 48;
	localparam int RATE_W    = 32;
	localparam int BYTE_W    = 24;
	localparam int MULT_W    = 16;
	localparam int MULT_FRAC = 8;
	localparam int ALPHA_W   = 16;
	localparam int CFG_W     = RATE_W;
	localparam int CFG_IDX_W = 2;

	// microseconds per second and the bits it needs
	localparam int US_W = 20;
	localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);

	localparam int BUS_W = BYTE_W + US_W;
	localparam int NUM_W = BUS_W + MULT_FRAC;
	localparam int DEN_W = MULT_W + RATE_W;

	localparam int DIV_N_W   = NUM_W;
	localparam int DIV_D_W   = (DEN_W > TIME_W) ? DEN_W : TIME_W;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	localparam int MUL_A_W  = (RATE_W > BYTE_W) ? RATE_W : BYTE_W;
	localparam int MUL_B0_W = (US_W > MULT_W) ? US_W : MULT_W;
	localparam int MUL_B_W  = (MUL_B0_W > ALPHA_W + 1) ? MUL_B0_W : ALPHA_W + 1;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

	localparam int SUM_W = ((NUM_W > TIME_W) ? NUM_W : TIME_W) + 1;

	localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(1250000);
	localparam logic [MULT_W-1:0]  MULT_RESET  = MULT_W'(256);
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(58982);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_RATE = 2'd0,
		CFG_RATE_MULT    = 2'd1,
		CFG_ALPHA        = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BYTES,
		ST_BYTES_W,
		ST_DEN,
		ST_DEN_W,
		ST_PDIV,
		ST_PDIV_W,
		ST_PADD,
		ST_ELAP,
		ST_EDIV_W,
		ST_MUL1,
		ST_MUL1_W,
		ST_MUL2,
		ST_MUL2_W,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic               start;
		logic               accum;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] n;
		logic [DIV_D_W-1:0] d;
	} div_req_t;

endpackage

FILE: src/send_pacer_with_rate_estimate_top.sv
// send_pacer_with_rate_estimate_top: one transaction in, one result out.
// Work per event: the 20-step multiply by 1e6, up to two divider passes and the bit-serial
// gain and alpha multiplies; a zero byte count skips all of them.
// Throughput: one event in flight; the next is taken the cycle after its result moves to the
// output register. Reset: times clear, rate loads 1250000, gain 1.0, alpha 0.9.
`timescale 1ns / 1ps

module send_pacer_with_rate_estimate_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spre_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [spre_pkg::TIME_W-1:0]    now_us,
	input  logic [spre_pkg::BYTE_W-1:0]    byte_count,
	input  logic                           pace,
	input  logic                           estimate,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [spre_pkg::TIME_W-1:0]    wait_us,
	output logic [spre_pkg::RATE_W-1:0]    rate_estimate,
	output logic                           status
);

	localparam logic [spre_pkg::TIME_W-1:0] TMAX = {spre_pkg::TIME_W{1'b1}};

	spre_pkg::st_t state_q, state_d;

	logic [spre_pkg::TIME_W-1:0]  now_q;
	logic [spre_pkg::BYTE_W-1:0]  bytes_q;
	logic                         pace_q;
	logic                         est_q;
	logic [spre_pkg::BUS_W-1:0]   bus_q;
	logic                         zden_q;
	logic [spre_pkg::RATE_W-1:0]  sample_q;
	logic [spre_pkg::TIME_W-1:0]  nst_q;
	logic [spre_pkg::TIME_W-1:0]  lut_q;
	logic [spre_pkg::RATE_W-1:0]  rate_q;
	logic [spre_pkg::MULT_W-1:0]  mult_q;
	logic [spre_pkg::ALPHA_W-1:0] alpha_q;
	logic                         out_valid_q;
	logic [spre_pkg::TIME_W-1:0]  wait_q;
	logic [spre_pkg::RATE_W-1:0]  rate_out_q;
	logic                         status_q;

	spre_pkg::mul_req_t           mreq;
	spre_pkg::div_req_t           dreq;
	logic                         mul_done;
	logic                         div_done;
	logic [spre_pkg::MUL_P_W-1:0] mul_p;
	logic [spre_pkg::DIV_N_W-1:0] div_q;

	logic                         accept;
	logic                         out_free;
	logic [spre_pkg::ALPHA_W:0]   alpha_cmp;
	logic [spre_pkg::TIME_W-1:0]  elapsed;
	logic [spre_pkg::DEN_W-1:0]   den;
	logic [spre_pkg::SUM_W-1:0]   delta;
	logic [spre_pkg::SUM_W-1:0]   psum;
	logic [spre_pkg::TIME_W-1:0]  nst_next;
	logic [spre_pkg::RATE_W-1:0]  sample_sat;
	logic [spre_pkg::RATE_W-1:0]  rate_new;
	logic [spre_pkg::TIME_W-1:0]  wait_calc;

	spre_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.p      (mul_p)
	);

	spre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.q      (div_q)
	);

	assign in_ready = (state_q == spre_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// weight of the new sample, 2^16 - alpha
	assign alpha_cmp = {1'b1, {spre_pkg::ALPHA_W{1'b0}}} - {1'b0, alpha_q};
	assign elapsed   = (now_q > lut_q) ? (now_q - lut_q) : spre_pkg::TIME_W'(1);
	assign den       = mul_p[spre_pkg::DEN_W-1:0];
	assign delta     = zden_q ? spre_pkg::SUM_W'(TMAX) : spre_pkg::SUM_W'(div_q);
	assign psum      = spre_pkg::SUM_W'(nst_q) + delta;
	assign nst_next  = (psum > spre_pkg::SUM_W'(TMAX)) ? TMAX : psum[spre_pkg::TIME_W-1:0];
	assign sample_sat = (|div_q[spre_pkg::DIV_N_W-1:spre_pkg::RATE_W]) ?
		{spre_pkg::RATE_W{1'b1}} : div_q[spre_pkg::RATE_W-1:0];
	assign rate_new  = mul_p[spre_pkg::ALPHA_W +: spre_pkg::RATE_W];
	assign wait_calc = (nst_q > now_q) ? (nst_q - now_q) : '0;

	always_comb begin
		state_d = state_q;
		mreq    = '0;
		dreq    = '0;
		case (state_q)
			spre_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = spre_pkg::ST_BYTES;
				end
			end
			spre_pkg::ST_BYTES: begin
				if (bytes_q == '0) begin
					state_d = spre_pkg::ST_OUT;
				end else begin
					mreq.start = 1'b1;
					mreq.a     = spre_pkg::MUL_A_W'(bytes_q);
					mreq.b     = spre_pkg::MUL_B_W'(spre_pkg::US_PER_S);
					state_d    = spre_pkg::ST_BYTES_W;
				end
			end
			spre_pkg::ST_BYTES_W: begin
				if (mul_done) begin
					if (pace_q) begin
						state_d = spre_pkg::ST_DEN;
					end else if (est_q) begin
						state_d = spre_pkg::ST_ELAP;
					end else begin
						state_d = spre_pkg::ST_OUT;
					end
				end
			end
			spre_pkg::ST_DEN: begin
				mreq.start = 1'b1;
				mreq.a     = spre_pkg::MUL_A_W'(rate_q);
				mreq.b     = spre_pkg::MUL_B_W'(mult_q);
				state_d    = spre_pkg::ST_DEN_W;
			end
			spre_pkg::ST_DEN_W: begin
				if (mul_done) begin
					state_d = spre_pkg::ST_PDIV;
				end
			end
			spre_pkg::ST_PDIV: begin
				// zero gain: the step saturates and no division runs
				if (den == '0) begin
					state_d = spre_pkg::ST_PADD;
				end else begin
					dreq.start = 1'b1;
					dreq.n     = {bus_q, {spre_pkg::MULT_FRAC{1'b0}}};
					dreq.d     = spre_pkg::DIV_D_W'(den);
					state_d    = spre_pkg::ST_PDIV_W;
				end
			end
			spre_pkg::ST_PDIV_W: begin
				if (div_done) begin
					state_d = spre_pkg::ST_PADD;
				end
			end
			spre_pkg::ST_PADD: begin
				state_d = est_q ? spre_pkg::ST_ELAP : spre_pkg::ST_OUT;
			end
			spre_pkg::ST_ELAP: begin
				dreq.start = 1'b1;
				dreq.n     = spre_pkg::DIV_N_W'(bus_q);
				dreq.d     = spre_pkg::DIV_D_W'(elapsed);
				state_d    = spre_pkg::ST_EDIV_W;
			end
			spre_pkg::ST_EDIV_W: begin
				if (div_done) begin
					state_d = spre_pkg::ST_MUL1;
				end
			end
			spre_pkg::ST_MUL1: begin
				mreq.start = 1'b1;
				mreq.a     = spre_pkg::MUL_A_W'(rate_q);
				mreq.b     = spre_pkg::MUL_B_W'(alpha_q);
				state_d    = spre_pkg::ST_MUL1_W;
			end
			spre_pkg::ST_MUL1_W: begin
				if (mul_done) begin
					state_d = spre_pkg::ST_MUL2;
				end
			end
			spre_pkg::ST_MUL2: begin
				mreq.start = 1'b1;
				mreq.accum = 1'b1;
				mreq.a     = spre_pkg::MUL_A_W'(sample_q);
				mreq.b     = spre_pkg::MUL_B_W'(alpha_cmp);
				state_d    = spre_pkg::ST_MUL2_W;
			end
			spre_pkg::ST_MUL2_W: begin
				if (mul_done) begin
					state_d = spre_pkg::ST_OUT;
				end
			end
			spre_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = spre_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spre_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spre_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// architectural state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nst_q       <= '0;
			lut_q       <= '0;
			rate_q      <= spre_pkg::RATE_RESET;
			mult_q      <= spre_pkg::MULT_RESET;
			alpha_q     <= spre_pkg::ALPHA_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					spre_pkg::CFG_INITIAL_RATE: begin
						rate_q <= (cfg_wdata == '0) ? spre_pkg::RATE_W'(1) : cfg_wdata;
					end
					spre_pkg::CFG_RATE_MULT: begin
						mult_q <= cfg_wdata[spre_pkg::MULT_W-1:0];
					end
					spre_pkg::CFG_ALPHA: begin
						alpha_q <= cfg_wdata[spre_pkg::ALPHA_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (state_q == spre_pkg::ST_PADD) begin
				nst_q <= nst_next;
			end
			if ((state_q == spre_pkg::ST_MUL2_W) && mul_done) begin
				rate_q <= (rate_new == '0) ? spre_pkg::RATE_W'(1) : rate_new;
				lut_q  <= now_q;
			end
			if ((state_q == spre_pkg::ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= now_us;
			bytes_q <= byte_count;
			pace_q  <= pace;
			est_q   <= estimate;
		end
		if ((state_q == spre_pkg::ST_BYTES_W) && mul_done) begin
			bus_q <= mul_p[spre_pkg::BUS_W-1:0];
		end
		if (state_q == spre_pkg::ST_PDIV) begin
			zden_q <= (den == '0);
		end
		if ((state_q == spre_pkg::ST_EDIV_W) && div_done) begin
			sample_q <= sample_sat;
		end
		if ((state_q == spre_pkg::ST_OUT) && out_free) begin
			wait_q     <= wait_calc;
			rate_out_q <= rate_q;
			status_q   <= (bytes_q == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign wait_us       = wait_q;
	assign rate_estimate = rate_out_q;
	assign status        = status_q;

endmodule

FILE: src/spre_mul.sv
// spre_mul: bit-serial shift-and-add multiplier, one multiplier bit per cycle,
// stops as soon as the remaining multiplier bits are zero.
// Depends on spre_pkg.
`timescale 1ns / 1ps

module spre_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spre_pkg::mul_req_t         req,
	output logic                       done,
	output logic [spre_pkg::MUL_P_W-1:0] p
);

	logic [spre_pkg::MUL_P_W-1:0] a_q;
	logic [spre_pkg::MUL_B_W-1:0] b_q;
	logic [spre_pkg::MUL_P_W-1:0] acc_q;
	logic                         busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= spre_pkg::MUL_P_W'(req.a);
			b_q <= req.b;
			// accumulate mode keeps the previous product for a sum of two
			if (!req.accum) begin
				acc_q <= '0;
			end
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[spre_pkg::MUL_P_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[spre_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = busy_q && (b_q == '0);
	assign p    = acc_q;

endmodule

FILE: src/spre_div.sv
// spre_div: radix-2 restoring divider, one quotient bit per cycle.
// The quotient shifts in where the dividend shifts out. Depends on spre_pkg.
`timescale 1ns / 1ps

module spre_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spre_pkg::div_req_t           req,
	output logic                         done,
	output logic [spre_pkg::DIV_N_W-1:0] q
);

	logic [spre_pkg::DIV_N_W-1:0]   n_q;
	logic [spre_pkg::DIV_D_W-1:0]   d_q;
	logic [spre_pkg::DIV_D_W-1:0]   rem_q;
	logic [spre_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic [spre_pkg::DIV_D_W:0]     trial;
	logic [spre_pkg::DIV_D_W:0]     diff;
	logic                           ge;

	assign trial = {rem_q, n_q[spre_pkg::DIV_N_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (cnt_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.n;
			d_q   <= req.d;
			rem_q <= '0;
			cnt_q <= spre_pkg::DIV_CNT_W'(spre_pkg::DIV_N_W);
		end else if (busy_q && (cnt_q != '0)) begin
			// remainder stays below the divisor, so it fits the divisor width
			rem_q <= ge ? diff[spre_pkg::DIV_D_W-1:0] : trial[spre_pkg::DIV_D_W-1:0];
			n_q   <= {n_q[spre_pkg::DIV_N_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign q    = n_q;

endmodule

FILE: src/spre_chk.sv
// spre_chk: port-level checks on the send pacer top level, attached by bind.
// Depends on spre_pkg and send_pacer_with_rate_estimate_top.
`timescale 1ns / 1ps

module spre_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [spre_pkg::TIME_W-1:0]    now_us,
	input logic [spre_pkg::BYTE_W-1:0]    byte_count,
	input logic                           pace,
	input logic                           estimate,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [spre_pkg::TIME_W-1:0]    wait_us,
	input logic [spre_pkg::RATE_W-1:0]    rate_estimate,
	input logic                           status
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wait_us) &&
		$stable(rate_estimate) && $stable(status))
		else $error("result changed while stalled");

	// a waiting transaction holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(now_us) &&
		$stable(byte_count) && $stable(pace) && $stable(estimate))
		else $error("transaction changed while waiting");

	// one event at a time: no new transaction right after one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");

	// the rate estimate never reaches zero
	a_rate_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rate_estimate != '0)
		else $error("zero rate estimate");

	// a result does not rise right after its transaction is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind send_pacer_with_rate_estimate_top spre_chk u_spre_chk (.*);
